// ===== hw/rtl/c3dc_pkg.sv =====
// c3dc_pkg: shared types, widths and codes of the 3x3 convolution block
// no dependencies; used by every module of the block but c3dc_linebuf
`timescale 1ns / 1ps
`default_nettype none

package c3dc_pkg;

  // field and register widths fixed by the interface
  localparam int PixW      = 8;
  localparam int CoefW     = 16;
  localparam int KernW     = 3 * CoefW;
  localparam int CfgSizeW  = 11;
  localparam int DivW      = 15;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = KernW;
  localparam int CoordW    = 10;
  localparam int OutDataW  = 32;
  localparam int InDataW   = 8;

  // datapath widths: 9-bit signed pixel times 16-bit coefficient, sum of nine
  localparam int ProdW     = PixW + 1 + CoefW;
  localparam int SumW      = ProdW + 3;
  localparam int QuotW     = PixW + 1;

  localparam int Taps      = 9;
  localparam int TapIdxW   = 4;

  localparam logic [PixW-1:0] PixMax = 8'd255;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH     = 3'd0,
    CFG_HEIGHT    = 3'd1,
    CFG_KERN_TOP  = 3'd2,
    CFG_KERN_MID  = 3'd3,
    CFG_KERN_BOT  = 3'd4,
    CFG_DIVISOR   = 3'd5
  } cfg_reg_e;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

  // 3x3 window, index row*3+col, column 2 newest
  typedef logic [Taps-1:0][PixW-1:0]  win_t;
  typedef logic [Taps-1:0][CoefW-1:0] coef_t;

endpackage

`default_nettype wire

// ===== hw/rtl/c3dc_linebuf.sv =====
// c3dc_linebuf: line store memory, one entry per column holding both stored rows
// depends on nothing; one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module c3dc_linebuf #(
  parameter int Depth = 1024,
  parameter int DataW = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  // synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/c3dc_mac.sv =====
// c3dc_mac: nine-step multiply-accumulate over the 3x3 window
// depends on c3dc_pkg; one shared 9x16 signed multiplier, product registered
`timescale 1ns / 1ps
`default_nettype none

module c3dc_mac (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire c3dc_pkg::win_t                   win_i,
  input  wire c3dc_pkg::coef_t                  coef_i,
  output logic                                  done_o,
  output logic signed [c3dc_pkg::SumW-1:0]      sum_o
);

  logic [c3dc_pkg::TapIdxW-1:0]       cnt_q;
  logic                               busy_q;
  logic                               pvld_q;
  logic                               done_q;
  logic signed [c3dc_pkg::ProdW-1:0]  prod_d;
  logic signed [c3dc_pkg::ProdW-1:0]  prod_q;
  logic signed [c3dc_pkg::SumW-1:0]   acc_q;

  // one tap per cycle through the shared multiplier
  always_comb begin
    prod_d = $signed({1'b0, win_i[cnt_q]}) * $signed(coef_i[cnt_q]);
  end

  // tap counter and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      pvld_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= pvld_q && !busy_q;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
        pvld_q <= 1'b0;
      end else begin
        pvld_q <= busy_q;
        if (busy_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == c3dc_pkg::TapIdxW'(c3dc_pkg::Taps - 1)) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  // product register and accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start_i) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= acc_q + {{(c3dc_pkg::SumW - c3dc_pkg::ProdW){prod_q[c3dc_pkg::ProdW-1]}}, prod_q};
    end
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/c3dc_div.sv =====
// c3dc_div: restoring divider with clamp to 0..255
// depends on c3dc_pkg; one quotient bit per cycle, nine bits, top bit flags overflow
`timescale 1ns / 1ps
`default_nettype none

module c3dc_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [c3dc_pkg::SumW-1:0]   sum_i,
  input  wire logic [c3dc_pkg::DivW-1:0]          divisor_i,
  output logic                                    done_o,
  output logic [c3dc_pkg::PixW-1:0]              value_o
);

  localparam int RemW = c3dc_pkg::SumW - 1;
  localparam int DshW = c3dc_pkg::DivW + c3dc_pkg::QuotW - 1;

  logic [c3dc_pkg::TapIdxW-1:0]  step_q;
  logic                          busy_q;
  logic                          done_q;
  logic [RemW-1:0]               rem_q;
  logic [DshW-1:0]               dsh_q;
  logic [c3dc_pkg::QuotW-1:0]    quot_q;
  logic [c3dc_pkg::DivW-1:0]     div_eff;
  logic [RemW-1:0]               dsh_ext;
  logic                          ge;

  // zero divisor acts as one
  assign div_eff = (divisor_i == '0) ? c3dc_pkg::DivW'(1) : divisor_i;

  // compare for the current quotient bit
  assign dsh_ext = RemW'(dsh_q);
  assign ge      = (rem_q >= dsh_ext);

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == c3dc_pkg::TapIdxW'(c3dc_pkg::QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder, shifted divisor and quotient; a negative sum divides as zero
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= sum_i[c3dc_pkg::SumW-1] ? '0 : sum_i[RemW-1:0];
      dsh_q  <= {div_eff, {(c3dc_pkg::QuotW - 1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_ext;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[c3dc_pkg::QuotW-2:0], ge};
    end
  end

  // quotient of 256 or more saturates
  assign value_o = quot_q[c3dc_pkg::QuotW-1] ? c3dc_pkg::PixMax
                                             : quot_q[c3dc_pkg::PixW-1:0];
  assign done_o  = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/conv3x3_divide_clamp_top.sv =====
// conv3x3_divide_clamp_top: 3x3 integer convolution, divide and clamp of a pixel stream
// depends on c3dc_pkg, c3dc_linebuf, c3dc_mac and c3dc_div
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[7:0] pixel_in, tuser frame_start
//  m_axis    out  tvalid/tready         tdata filtered_value/out_row/out_col, tlast
//  cfg       in   cfg_we_i (no wait)    cfg_idx_i register, cfg_data_i value
//
//  a border pixel is accepted with its line store read, then shifts the window and is written back
//  an interior pixel then goes on through the shared multiplier and the divider
//  a result moves into the output register when it is free; the next pixel is then taken at once
//  line stores are not cleared after reset; rows and columns restart at zero
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_divide_clamp_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [c3dc_pkg::InDataW-1:0]     s_axis_tdata_i,  // [7:0] pixel_in
  input  wire logic                             s_axis_tuser_i,  // [0] frame_start
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic [c3dc_pkg::OutDataW-1:0]         m_axis_tdata_o,  // [7:0] filtered_value,
                                                                 // [17:8] out_row,
                                                                 // [27:18] out_col
  output logic                                  m_axis_tlast_o,  // last_of_plane
  input  wire logic                             cfg_we_i,
  input  wire logic [c3dc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [c3dc_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int WidW = $clog2(MAX_WIDTH + 1);
  localparam int HgtW = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int PW   = c3dc_pkg::PixW;
  localparam int LbW  = 2 * PW;

  // configuration registers
  logic [c3dc_pkg::CfgSizeW-1:0] width_q;
  logic [c3dc_pkg::CfgSizeW-1:0] height_q;
  logic [c3dc_pkg::KernW-1:0]    kern_top_q;
  logic [c3dc_pkg::KernW-1:0]    kern_mid_q;
  logic [c3dc_pkg::KernW-1:0]    kern_bot_q;
  logic [c3dc_pkg::DivW-1:0]     divisor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= c3dc_pkg::CfgSizeW'(1024);
      height_q   <= c3dc_pkg::CfgSizeW'(1024);
      kern_top_q <= '0;
      kern_mid_q <= c3dc_pkg::KernW'(65536);
      kern_bot_q <= '0;
      divisor_q  <= c3dc_pkg::DivW'(1);
    end else if (cfg_we_i) begin
      unique case (c3dc_pkg::cfg_reg_e'(cfg_idx_i))
        c3dc_pkg::CFG_WIDTH:    width_q    <= cfg_data_i[c3dc_pkg::CfgSizeW-1:0];
        c3dc_pkg::CFG_HEIGHT:   height_q   <= cfg_data_i[c3dc_pkg::CfgSizeW-1:0];
        c3dc_pkg::CFG_KERN_TOP: kern_top_q <= cfg_data_i;
        c3dc_pkg::CFG_KERN_MID: kern_mid_q <= cfg_data_i;
        c3dc_pkg::CFG_KERN_BOT: kern_bot_q <= cfg_data_i;
        c3dc_pkg::CFG_DIVISOR:  divisor_q  <= cfg_data_i[c3dc_pkg::DivW-1:0];
        default: ;
      endcase
    end
  end

  // plane size limited to 1..max
  logic [31:0]     width_ext;
  logic [31:0]     height_ext;
  logic [WidW-1:0] w_eff;
  logic [HgtW-1:0] h_eff;

  assign width_ext  = 32'(width_q);
  assign height_ext = 32'(height_q);
  assign w_eff = (width_ext == 32'd0) ? WidW'(1) :
                 (width_ext > 32'(MAX_WIDTH)) ? WidW'(MAX_WIDTH) : width_ext[WidW-1:0];
  assign h_eff = (height_ext == 32'd0) ? HgtW'(1) :
                 (height_ext > 32'(MAX_HEIGHT)) ? HgtW'(MAX_HEIGHT) : height_ext[HgtW-1:0];

  // sequencer and handshake signals
  c3dc_pkg::state_e state_q, state_d;
  logic in_accept;
  logic slot_free;
  logic mac_start;
  logic mac_done;
  logic div_start;
  logic div_done;
  logic out_load;
  logic mem_wr_en;

  assign s_axis_tready_o = (state_q == c3dc_pkg::ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // position of the incoming pixel and of the one after it
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] cur_row_q;
  logic [ColW-1:0] cur_col_q;
  logic [PW-1:0]   pix_q;
  logic            interior_q;
  logic            last_q;
  logic [WidW-1:0] c0, c1, cn;
  logic [HgtW-1:0] r0, r1, rn;
  logic            interior_d;
  logic            last_d;

  always_comb begin
    c0 = s_axis_tuser_i ? '0 : WidW'(col_q);
    r0 = s_axis_tuser_i ? '0 : HgtW'(row_q);
    // column past a narrowed width moves to the next row
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    if (r1 >= h_eff) begin
      r1 = '0;
    end
    // advance for the following pixel, wrapping at the plane end
    cn = c1 + 1'b1;
    rn = r1;
    if (cn >= w_eff) begin
      cn = '0;
      rn = r1 + 1'b1;
      if (rn >= h_eff) begin
        rn = '0;
      end
    end
    interior_d = (r1 >= HgtW'(2)) && (c1 >= WidW'(2));
    last_d     = (r1 == h_eff - 1'b1) && (c1 == w_eff - 1'b1);
    col_d      = cn[ColW-1:0];
    row_d      = rn[RowW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_row_q  <= r1[RowW-1:0];
      cur_col_q  <= c1[ColW-1:0];
      pix_q      <= s_axis_tdata_i[PW-1:0];
      interior_q <= interior_d;
      last_q     <= last_d;
    end
  end

  // line store: upper row in the high byte, lower row in the low byte;
  // read at accept, written back the cycle after, one pixel in flight at a time
  logic [LbW-1:0] lb_rd_data;

  c3dc_linebuf #(
    .Depth (MAX_WIDTH),
    .DataW (LbW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (c1[ColW-1:0]),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (cur_col_q),
    .wr_data_i ({lb_rd_data[PW-1:0], pix_q})
  );

  // 3x3 window shift
  c3dc_pkg::win_t win_q;

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]     <= win_q[k*3 + 1];
        win_q[k*3 + 1] <= win_q[k*3 + 2];
      end
      win_q[2] <= lb_rd_data[LbW-1:PW];
      win_q[5] <= lb_rd_data[PW-1:0];
      win_q[8] <= pix_q;
    end
  end

  // coefficients, left one in the low bits of each row register
  c3dc_pkg::coef_t coef;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef[j]     = kern_top_q[j*c3dc_pkg::CoefW +: c3dc_pkg::CoefW];
      coef[3 + j] = kern_mid_q[j*c3dc_pkg::CoefW +: c3dc_pkg::CoefW];
      coef[6 + j] = kern_bot_q[j*c3dc_pkg::CoefW +: c3dc_pkg::CoefW];
    end
  end

  logic signed [c3dc_pkg::SumW-1:0] sum;
  logic [PW-1:0]                    div_value;

  c3dc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .win_i   (win_q),
    .coef_i  (coef),
    .done_o  (mac_done),
    .sum_o   (sum)
  );

  c3dc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (sum),
    .divisor_i (divisor_q),
    .done_o    (div_done),
    .value_o   (div_value)
  );

  // output register frees the sequencer while a result waits
  logic                          out_valid_q;
  logic [c3dc_pkg::OutDataW-1:0] out_data_q;
  logic                          out_last_q;
  logic [31:0]                   row_m1;
  logic [31:0]                   col_m1;

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign row_m1    = 32'(cur_row_q) - 32'd1;
  assign col_m1    = 32'(cur_col_q) - 32'd1;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c3dc_pkg::ST_IDLE:  if (in_accept) state_d = c3dc_pkg::ST_SHIFT;
      c3dc_pkg::ST_SHIFT: state_d = interior_q ? c3dc_pkg::ST_MAC : c3dc_pkg::ST_IDLE;
      c3dc_pkg::ST_MAC:   if (mac_done) state_d = c3dc_pkg::ST_DIV;
      c3dc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = slot_free ? c3dc_pkg::ST_IDLE : c3dc_pkg::ST_OUT;
        end
      end
      c3dc_pkg::ST_OUT:   if (slot_free) state_d = c3dc_pkg::ST_IDLE;
      default:            state_d = c3dc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_wr_en = 1'b0;
    mac_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      c3dc_pkg::ST_IDLE: ;
      c3dc_pkg::ST_SHIFT: begin
        mem_wr_en = 1'b1;
        mac_start = interior_q;
      end
      c3dc_pkg::ST_MAC:   div_start = mac_done;
      c3dc_pkg::ST_DIV:   out_load  = div_done && slot_free;
      c3dc_pkg::ST_OUT:   out_load  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= c3dc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {{(c3dc_pkg::OutDataW - PW - 2*c3dc_pkg::CoordW){1'b0}},
                     col_m1[c3dc_pkg::CoordW-1:0], row_m1[c3dc_pkg::CoordW-1:0], div_value};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // a pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result loaded over a pending one");

  // the line store is written back in the cycle after its read
  a_wb_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> $past(in_accept))
    else $error("line store write without a preceding read");

  // the sum is ready only while the sequencer waits for it
  a_mac_in_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == c3dc_pkg::ST_MAC))
    else $error("sum finished outside the accumulate phase");

  // the quotient is ready only while the sequencer waits for it
  a_div_in_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == c3dc_pkg::ST_DIV))
    else $error("quotient finished outside the divide phase");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for conv3x3_divide_clamp_top, the 3x3 filter on a pixel stream
// depends on c3dc_pkg and the block's rtl; every accepted pixel runs through an in-bench
// convolution predictor and each filtered result is checked against the oldest prediction
`timescale 1ns / 1ps

module testbench;
  import c3dc_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int SETTLE       = 40;        // longer than an interior pixel takes
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400_000;

  typedef struct {
    logic [PixW-1:0]   value;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              plane_end;
  } filtered_t;

  // block ports
  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                pix_valid = 1'b0;
  logic                pix_ready;
  logic [InDataW-1:0]  pix_data  = '0;
  logic                pix_first = 1'b0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [OutDataW-1:0] res_data;
  logic                res_last;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // predictor copy of the registers, reset values
  logic [10:0]         cfg_width   = 11'd1024;
  logic [10:0]         cfg_height  = 11'd1024;
  logic [KernW-1:0]    cfg_kernel [3] = '{48'd0, 48'h10000, 48'd0};
  logic [DivW-1:0]     cfg_divisor = 15'd1;

  // predictor copy of line stores, window and counters; *_ok marks defined entries
  bit [PixW-1:0] line_two_up [MAX_W];
  bit [PixW-1:0] line_one_up [MAX_W];
  bit            two_up_ok   [MAX_W];
  bit            one_up_ok   [MAX_W];
  bit [PixW-1:0] win_pix     [9];
  bit            win_ok      [9];
  int            next_row = 0;
  int            next_col = 0;

  filtered_t pending_filtered [$];

  int errors        = 0;
  int items_sent    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  conv3x3_divide_clamp_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (pix_valid),
    .s_axis_tready_o (pix_ready),
    .s_axis_tdata_i  (pix_data),   // [7:0] pixel_in
    .s_axis_tuser_i  (pix_first),  // [0] frame_start
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),   // [7:0] value, [17:8] row, [27:18] col
    .m_axis_tlast_o  (res_last),   // last_of_plane
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side ready: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // effective sizes after range limiting
  function automatic int eff_width();
    if (cfg_width < 1) return 1;
    if (cfg_width > MAX_W) return MAX_W;
    return int'(cfg_width);
  endfunction

  function automatic int eff_height();
    if (cfg_height < 1) return 1;
    if (cfg_height > MAX_H) return MAX_H;
    return int'(cfg_height);
  endfunction

  // position the next pixel lands on
  function automatic void locate_pixel(input bit first, output int r, output int c);
    r = next_row;
    c = next_col;
    if (first) begin
      r = 0;
      c = 0;
    end
    if (c >= eff_width()) begin
      c = 0;
      r++;
    end
    if (r >= eff_height()) r = 0;
  endfunction

  // true when a result at the next position uses only written entries
  function automatic bit window_defined(input bit first);
    int r, c;
    locate_pixel(first, r, c);
    if (r < 2 || c < 2) return 1'b1;
    return two_up_ok[c] && one_up_ok[c] && win_ok[1] && win_ok[2] &&
           win_ok[4] && win_ok[5] && win_ok[7] && win_ok[8];
  endfunction

  // predictor: window update, weighted sum, divide, clamp
  task automatic convolve_pixel(input logic [PixW-1:0] pix, input bit first);
    int        r, c, acc, dv, quot;
    shortint   coef;
    filtered_t res;
    locate_pixel(first, r, c);
    for (int k = 0; k < 3; k++) begin
      win_pix[k*3]   = win_pix[k*3+1];
      win_ok[k*3]    = win_ok[k*3+1];
      win_pix[k*3+1] = win_pix[k*3+2];
      win_ok[k*3+1]  = win_ok[k*3+2];
    end
    win_pix[2] = line_two_up[c];
    win_ok[2]  = two_up_ok[c];
    win_pix[5] = line_one_up[c];
    win_ok[5]  = one_up_ok[c];
    win_pix[8] = pix;
    win_ok[8]  = 1'b1;
    line_two_up[c] = line_one_up[c];
    two_up_ok[c]   = one_up_ok[c];
    line_one_up[c] = pix;
    one_up_ok[c]   = 1'b1;

    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef = cfg_kernel[i][16*j +: 16];
          acc += int'(win_pix[i*3+j]) * int'(coef);
        end
      end
      dv   = (cfg_divisor == 0) ? 1 : int'(cfg_divisor);
      quot = acc / dv;
      if (quot < 0) quot = 0;
      if (quot > 255) quot = 255;
      res.value     = 8'(quot);
      res.row       = 10'(r - 1);
      res.col       = 10'(c - 1);
      res.plane_end = (r == eff_height() - 1) && (c == eff_width() - 1);
      pending_filtered.push_back(res);
    end

    next_col = c + 1;
    next_row = r;
    if (next_col >= eff_width()) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= eff_height()) next_row = 0;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // result checker; sampled mid-cycle, the transfer happens at the next rising edge
  always @(negedge clk_i) begin : result_monitor
    filtered_t want;
    if (rst_ni && res_valid && res_ready) begin
      if (pending_filtered.size() == 0) begin
        $error("unexpected result: tdata %h, tlast %b", res_data, res_last);
        errors++;
      end else begin
        want = pending_filtered.pop_front();
        check_field("filtered_value", want.value, res_data[PixW-1:0]);
        check_field("out_row", want.row, res_data[PixW +: CoordW]);
        check_field("out_col", want.col, res_data[PixW+CoordW +: CoordW]);
        check_field("last_of_plane", want.plane_end, res_last);
        check_field("tdata padding", 0, res_data[OutDataW-1:PixW+2*CoordW]);
      end
    end
  end

  // one pixel request; called and returns at a rising edge
  task automatic send_pixel(input logic [PixW-1:0] pix, input bit first);
    // never let a result use a line store entry that was not written yet
    if (!window_defined(first)) first = 1'b1;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_valid <= 1'b1;
    pix_data  <= pix;
    pix_first <= first;
    do @(negedge clk_i); while (!pix_ready);
    @(posedge clk_i);
    convolve_pixel(pix, first);
    items_sent++;
  endtask

  // stop sending and let every outstanding result come out
  task automatic wait_results_drained();
    pix_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH:    cfg_width     = value[10:0];
      CFG_HEIGHT:   cfg_height    = value[10:0];
      CFG_KERN_TOP: cfg_kernel[0] = value;
      CFG_KERN_MID: cfg_kernel[1] = value;
      CFG_KERN_BOT: cfg_kernel[2] = value;
      CFG_DIVISOR:  cfg_divisor   = value[DivW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(input int w, input int h);
    wait_results_drained();
    write_reg(CFG_WIDTH, 48'(w));
    write_reg(CFG_HEIGHT, 48'(h));
  endtask

  task automatic set_kernel(input logic [KernW-1:0] top, input logic [KernW-1:0] mid,
                            input logic [KernW-1:0] bot, input logic [DivW-1:0] divisor);
    wait_results_drained();
    write_reg(CFG_KERN_TOP, top);
    write_reg(CFG_KERN_MID, mid);
    write_reg(CFG_KERN_BOT, bot);
    write_reg(CFG_DIVISOR, 48'(divisor));
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  function automatic logic [PixW-1:0] random_pixel();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // small, arbitrary or extreme coefficient
  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(16)) - 16'd8;
      1:       return 16'($urandom);
      2:       return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  function automatic logic [KernW-1:0] random_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [DivW-1:0] random_divisor();
    case ($urandom_range(3))
      0:       return 15'd0;
      1:       return 15'($urandom_range(1, 16));
      2:       return 15'($urandom_range(1, 32767));
      default: return 15'h7FFF;
    endcase
  endfunction

  // mostly small sizes, some below three, a few wider
  function automatic int pick_extent(input int top);
    int p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(3, 10);
    if (p < 92) return $urandom_range(1, 2);
    return $urandom_range(11, top);
  endfunction

  // a run of random pixels; rare stray frame starts inside
  task automatic send_run(input int count, input bit first);
    for (int i = 0; i < count; i++)
      send_pixel(random_pixel(), (i == 0) ? first : ($urandom_range(199) == 0));
  endtask

  // a run of random pixels with no stray frame starts
  task automatic send_clean_run(input int count, input bit first);
    for (int i = 0; i < count; i++)
      send_pixel(random_pixel(), (i == 0) ? first : 1'b0);
  endtask

  // reset kernel is the identity; one extra pixel wraps into the next plane
  task automatic test_reset_kernel();
    set_size(3, 3);
    send_run(10, 1'b1);
  endtask

  // full-scale coefficients, positive and negative overflow clamp, divisor zero
  task automatic test_coef_extremes();
    logic [PixW-1:0] pattern [15];
    pattern = '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,
                8'd17,  8'd200, 8'd0,   8'd255, 8'd90,
                8'd0,   8'd0,   8'd0,   8'd255, 8'd255};
    set_kernel({3{16'h7FFF}}, {16'h0003, 16'hFFFF, 16'h7FFF}, {3{16'h8000}}, 15'd0);
    set_size(5, 3);
    for (int i = 0; i < 15; i++) send_pixel(pattern[i], i == 0);
  endtask

  // largest divisor, with a truncating quotient
  task automatic test_divisor_limit();
    set_kernel(48'd0, {16'h7FFE, 16'h7FFF, 16'h7FFF}, 48'd0, 15'h7FFF);
    set_size(3, 3);
    send_run(9, 1'b1);
  endtask

  // widths of zero and two and a height of zero give no results
  task automatic test_small_images();
    set_size(0, 4);
    send_run(4, 1'b1);
    set_size(2, 3);
    send_run(6, 1'b1);
    set_size(4, 0);
    send_run(4, 1'b1);
  endtask

  // frame start in the middle of a plane restarts row and column
  task automatic test_frame_restart();
    set_kernel(random_row(), random_row(), random_row(), 15'd5);
    set_size(3, 3);
    send_run(4, 1'b1);
    send_run(9, 1'b1);
  endtask

  // width and height lowered under the running counters
  task automatic test_resize_mid_plane();
    set_size(6, 5);
    send_run(15, 1'b1);
    set_size(3, 5);
    send_run(3, 1'b0);
    set_size(3, 3);
    send_run(9, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_stall();
    set_size(8, 6);
    hold_seq <= hold_seq + 1;
    send_run(48, 1'b1);
  endtask

  // one random phase of well-formed planes, cut and long planes and resizes
  task automatic run_random_phase(input int target);
    int start, w, h, n, pick;
    bit first;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 65) begin
        if ($urandom_range(1)) set_kernel(random_row(), random_row(), random_row(),
                                          random_divisor());
        set_size(pick_extent(32), pick_extent(12));
      end
      w     = eff_width();
      h     = eff_height();
      n     = w * h;
      first = ($urandom_range(99) >= 15);
      pick  = $urandom_range(99);
      if (pick < 70) begin
        send_run(n, first);
      end else if (pick < 80) begin
        send_run($urandom_range(1, n), first);
      end else if (pick < 90) begin
        send_run(n + $urandom_range(1, 2 * w), first);
      end else begin
        send_run($urandom_range(1, n), first);
        set_size(pick_extent(32), pick_extent(12));
        send_run($urandom_range(1, 2 * n), 1'b0);
      end
    end
  endtask

  task automatic test_random_traffic();
    set_idling(35, 77);
    run_random_phase(220);
    set_idling(77, 35);
    run_random_phase(220);
    set_idling(0, 0);
    run_random_phase(220);
  endtask

  // sizes written above the maximum: a full-width row wraps at the largest width,
  // then a narrow plane goes on from the next row; a tall plane runs to row 19
  task automatic test_max_sizes();
    set_kernel(random_row(), random_row(), random_row(), random_divisor());
    set_size(2047, 3);
    send_clean_run(MAX_W, 1'b1);
    set_size(3, 3);
    send_clean_run(6, 1'b0);
    set_size(3, 2047);
    send_clean_run(60, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(35, 77);
    test_reset_kernel();
    test_coef_extremes();
    test_divisor_limit();
    test_small_images();
    test_frame_restart();
    test_resize_mid_plane();
    set_idling(0, 0);
    test_output_stall();
    test_random_traffic();
    test_max_sizes();
    wait_results_drained();

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
